### rtl/mmm_pkg.sv
// Shared types and constants for the matrix-matrix multiply core.
package mmm_pkg;

	// Default parameter values.
	localparam int MAX_DIM_DEF    = 8;
	localparam int ELEM_WIDTH_DEF = 16;

	// Fixed field widths.
	localparam int OPCODE_W    = 2;
	localparam int IDX_W       = 3;
	localparam int IN_ELEM_W   = 16;
	localparam int ELEM_MAX_W  = 32;
	localparam int DIM_W       = 4;
	localparam int CFG_IDX_W   = 2;
	localparam int SUM_W       = 32;

	// Dimension registers come out of reset at this value.
	localparam logic [DIM_W-1:0] DIM_RESET = 4'd8;

	// Queue depths between and behind the two halves.
	localparam int CMD_DEPTH   = 2;
	localparam int RES_DEPTH   = 4;
	localparam int RES_CNT_W   = $clog2(RES_DEPTH + 1);

	// Saturation limits of the result.
	localparam logic [SUM_W-1:0] SUM_MAX = 32'h7FFF_FFFF;
	localparam logic [SUM_W-1:0] SUM_MIN = 32'h8000_0000;

	// Input item opcodes.
	typedef enum logic [OPCODE_W-1:0] {
		OP_LOAD_A = 2'd0,
		OP_LOAD_B = 2'd1,
		OP_RUN    = 2'd2
	} opcode_t;

	// Configuration register indexes.
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ROWS_OF_FIRST  = 2'd0,
		REG_INNER_SIZE     = 2'd1,
		REG_COLS_OF_SECOND = 2'd2
	} cfg_reg_t;

	// Command kinds passed from the front end to the back end.
	typedef enum logic [1:0] {
		CMD_LOAD_A,
		CMD_LOAD_B,
		CMD_RUN
	} cmd_kind_t;

	// One decoded command.
	typedef struct packed {
		cmd_kind_t                kind;
		logic [IDX_W-1:0]         row;
		logic [IDX_W-1:0]         col;
		logic [ELEM_MAX_W-1:0]    elem;
		logic [DIM_W-1:0]         dim_m;
		logic [DIM_W-1:0]         dim_k;
		logic [DIM_W-1:0]         dim_n;
	} cmd_t;

	// One result element.
	typedef struct packed {
		logic [IDX_W-1:0] row;
		logic [IDX_W-1:0] col;
		logic [SUM_W-1:0] sum;
		logic             sat;
		logic             last;
	} result_t;

	// Back-end sequencer states.
	typedef enum logic {
		BACK_IDLE,
		BACK_RUN
	} back_state_t;

endpackage

### rtl/mmm_fifo.sv
// Small first-in first-out queue of generic entries with an occupancy count.
module mmm_fifo #(
	parameter type T     = logic,
	parameter int  DEPTH = 2
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         push,
	input  T                             wdata,
	output logic                         full,
	input  logic                         pop,
	output T                             rdata,
	output logic                         empty,
	output logic [$clog2(DEPTH+1)-1:0]   count
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	T                 entries_q [DEPTH];
	logic [PTR_W-1:0] wptr_q;
	logic [PTR_W-1:0] rptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	// A transaction only happens on the side that has room or data.
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign full    = (count_q == CNT_W'(DEPTH));
	assign empty   = (count_q == '0);
	assign count   = count_q;
	assign rdata   = entries_q[rptr_q];

	// Pointers and occupancy.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wptr_q <= (wptr_q == PTR_W'(DEPTH - 1)) ? '0 : wptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rptr_q <= (rptr_q == PTR_W'(DEPTH - 1)) ? '0 : rptr_q + PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	// Entry storage.
	always_ff @(posedge clk) begin
		if (do_push) begin
			entries_q[wptr_q] <= wdata;
		end
	end

endmodule

### rtl/mmm_front.sv
// Front end: holds the dimension registers and decodes input items into commands.
module mmm_front #(
	parameter int MAX_DIM = mmm_pkg::MAX_DIM_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// Input channel.
	input  logic                              push,
	output logic                              full,
	input  logic [mmm_pkg::OPCODE_W-1:0]      opcode,
	input  logic [mmm_pkg::IDX_W-1:0]         row_index,
	input  logic [mmm_pkg::IDX_W-1:0]         col_index,
	input  logic signed [mmm_pkg::IN_ELEM_W-1:0] element_value,
	// Configuration writes.
	input  logic                              wr_en,
	input  logic [mmm_pkg::CFG_IDX_W-1:0]     wr_index,
	input  logic [mmm_pkg::DIM_W-1:0]         wr_data,
	// Command queue.
	input  logic                              cmd_full,
	output logic                              cmd_push,
	output mmm_pkg::cmd_t                     cmd_data
);

	localparam int IDX_W = mmm_pkg::IDX_W;
	localparam int DIM_W = mmm_pkg::DIM_W;

	logic [DIM_W-1:0] rows_q;
	logic [DIM_W-1:0] inner_q;
	logic [DIM_W-1:0] cols_q;
	logic             accept;
	logic             in_range;

	// A zero dimension acts as one, any value above the array size as the array size.
	function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] r);
		logic [DIM_W-1:0] v;
		v = r;
		if (r == '0) begin
			v = DIM_W'(1);
		end else if (r > DIM_W'(MAX_DIM)) begin
			v = DIM_W'(MAX_DIM);
		end
		return v;
	endfunction

	// Dimension registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q  <= mmm_pkg::DIM_RESET;
			inner_q <= mmm_pkg::DIM_RESET;
			cols_q  <= mmm_pkg::DIM_RESET;
		end else if (wr_en) begin
			case (mmm_pkg::cfg_reg_t'(wr_index))
				mmm_pkg::REG_ROWS_OF_FIRST:  rows_q  <= wr_data;
				mmm_pkg::REG_INNER_SIZE:     inner_q <= wr_data;
				mmm_pkg::REG_COLS_OF_SECOND: cols_q  <= wr_data;
				default: ;
			endcase
		end
	end

	assign full   = cmd_full;
	assign accept = push && !cmd_full;

	// Loads outside the stored array are dropped.
	assign in_range = ({1'b0, row_index} < (IDX_W+1)'(MAX_DIM))
		&& ({1'b0, col_index} < (IDX_W+1)'(MAX_DIM));

	// Classify the transaction and build the command for the back end.
	always_comb begin
		cmd_push       = 1'b0;
		cmd_data.kind  = mmm_pkg::CMD_RUN;
		cmd_data.row   = row_index;
		cmd_data.col   = col_index;
		cmd_data.elem  = {{(mmm_pkg::ELEM_MAX_W - mmm_pkg::IN_ELEM_W)
			{element_value[mmm_pkg::IN_ELEM_W-1]}}, element_value};
		cmd_data.dim_m = eff_dim(rows_q);
		cmd_data.dim_k = eff_dim(inner_q);
		cmd_data.dim_n = eff_dim(cols_q);
		case (mmm_pkg::opcode_t'(opcode))
			mmm_pkg::OP_LOAD_A: begin
				cmd_data.kind = mmm_pkg::CMD_LOAD_A;
				cmd_push      = accept && in_range;
			end
			mmm_pkg::OP_LOAD_B: begin
				cmd_data.kind = mmm_pkg::CMD_LOAD_B;
				cmd_push      = accept && in_range;
			end
			mmm_pkg::OP_RUN: begin
				cmd_data.kind = mmm_pkg::CMD_RUN;
				cmd_push      = accept;
			end
			default: cmd_push = 1'b0;
		endcase
	end

endmodule

### rtl/mmm_back.sv
// Back end: element stores, product-sum sequencer and multiply-accumulate pipeline.
module mmm_back #(
	parameter int MAX_DIM    = mmm_pkg::MAX_DIM_DEF,
	parameter int ELEM_WIDTH = mmm_pkg::ELEM_WIDTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// Command queue.
	input  logic                           cmd_empty,
	input  mmm_pkg::cmd_t                  cmd_head,
	output logic                           cmd_pop,
	// Result queue.
	input  logic [mmm_pkg::RES_CNT_W-1:0]  res_count,
	output logic                           res_push,
	output mmm_pkg::result_t               res_data
);

	localparam int IDX_W   = mmm_pkg::IDX_W;
	localparam int DIM_W   = mmm_pkg::DIM_W;
	localparam int SUM_W   = mmm_pkg::SUM_W;
	localparam int CNT_W   = mmm_pkg::RES_CNT_W;
	localparam int DEPTH   = MAX_DIM * MAX_DIM;
	localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int PROD_W  = 2 * ELEM_WIDTH;
	localparam int ACC_RAW = PROD_W + $clog2(MAX_DIM) + 1;
	localparam int ACC_W   = (ACC_RAW > SUM_W + 1) ? ACC_RAW : SUM_W + 1;

	// Element stores.
	logic signed [ELEM_WIDTH-1:0] mem_a [DEPTH];
	logic signed [ELEM_WIDTH-1:0] mem_b [DEPTH];

	mmm_pkg::back_state_t state_q, state_d;

	logic [IDX_W-1:0] i_q, j_q, k_q;
	logic [DIM_W-1:0] m_q, kd_q, n_q;
	logic [CNT_W-1:0] inflight_q;

	logic              run_start;
	logic              issue;
	logic              k_last, j_last, i_last;
	logic              elem_done, run_done;
	logic [ADDR_W-1:0] wr_addr, rd_addr_a, rd_addr_b;
	logic [CNT_W:0]    credit_used;

	// Stage 1: read data.
	logic                         valid_s1, first_s1, last_s1, end_s1;
	logic [IDX_W-1:0]             row_s1, col_s1;
	logic signed [ELEM_WIDTH-1:0] a_s1, b_s1;
	// Stage 2: product.
	logic                         valid_s2, first_s2, last_s2, end_s2;
	logic [IDX_W-1:0]             row_s2, col_s2;
	logic signed [PROD_W-1:0]     prod_s2;
	// Stage 3: finished sum in the accumulator.
	logic                         valid_s3, end_s3;
	logic [IDX_W-1:0]             row_s3, col_s3;
	logic signed [ACC_W-1:0]      acc_q;
	logic signed [ACC_W-1:0]      acc_next;
	logic [ACC_W-SUM_W:0]         acc_top;
	logic                         acc_fits;

	// Loop end conditions.
	assign k_last = ((DIM_W'(k_q) + DIM_W'(1)) == kd_q);
	assign j_last = ((DIM_W'(j_q) + DIM_W'(1)) == n_q);
	assign i_last = ((DIM_W'(i_q) + DIM_W'(1)) == m_q);

	// A new result element starts only when the result queue has room for it.
	assign credit_used = (CNT_W+1)'(res_count) + (CNT_W+1)'(inflight_q);
	assign issue = (state_q == mmm_pkg::BACK_RUN)
		&& ((k_q != '0) || (credit_used < (CNT_W+1)'(mmm_pkg::RES_DEPTH)));
	assign elem_done = issue && k_last;
	assign run_done  = elem_done && j_last && i_last;

	assign wr_addr   = ADDR_W'(cmd_head.row * MAX_DIM + cmd_head.col);
	assign rd_addr_a = ADDR_W'(i_q * MAX_DIM + k_q);
	assign rd_addr_b = ADDR_W'(k_q * MAX_DIM + j_q);

	// Sequencer state register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mmm_pkg::BACK_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state: a load is taken while idle, a run stays until its last product.
	always_comb begin
		state_d   = state_q;
		cmd_pop   = 1'b0;
		run_start = 1'b0;
		case (state_q)
			mmm_pkg::BACK_IDLE: begin
				cmd_pop = !cmd_empty;
				if (!cmd_empty && cmd_head.kind == mmm_pkg::CMD_RUN) begin
					run_start = 1'b1;
					state_d   = mmm_pkg::BACK_RUN;
				end
			end
			mmm_pkg::BACK_RUN: begin
				if (run_done) begin
					state_d = mmm_pkg::BACK_IDLE;
				end
			end
			default: state_d = mmm_pkg::BACK_IDLE;
		endcase
	end

	// Row, column and inner loop counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			i_q  <= '0;
			j_q  <= '0;
			k_q  <= '0;
			m_q  <= mmm_pkg::DIM_RESET;
			kd_q <= mmm_pkg::DIM_RESET;
			n_q  <= mmm_pkg::DIM_RESET;
		end else if (run_start) begin
			i_q  <= '0;
			j_q  <= '0;
			k_q  <= '0;
			m_q  <= cmd_head.dim_m;
			kd_q <= cmd_head.dim_k;
			n_q  <= cmd_head.dim_n;
		end else if (issue) begin
			if (!k_last) begin
				k_q <= k_q + IDX_W'(1);
			end else begin
				k_q <= '0;
				if (!j_last) begin
					j_q <= j_q + IDX_W'(1);
				end else begin
					j_q <= '0;
					i_q <= i_q + IDX_W'(1);
				end
			end
		end
	end

	// Element stores: loads write, the sequencer reads one element of each.
	always_ff @(posedge clk) begin
		if (cmd_pop && cmd_head.kind == mmm_pkg::CMD_LOAD_A) begin
			mem_a[wr_addr] <= cmd_head.elem[ELEM_WIDTH-1:0];
		end
		if (cmd_pop && cmd_head.kind == mmm_pkg::CMD_LOAD_B) begin
			mem_b[wr_addr] <= cmd_head.elem[ELEM_WIDTH-1:0];
		end
		if (issue) begin
			a_s1 <= mem_a[rd_addr_a];
			b_s1 <= mem_b[rd_addr_b];
		end
	end

	// Running sum: the first product of an element restarts it.
	assign acc_next = (first_s2 ? '0 : acc_q)
		+ {{(ACC_W - PROD_W){prod_s2[PROD_W-1]}}, prod_s2};

	// Pipeline valid bits and the count of results not yet queued.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1   <= 1'b0;
			valid_s2   <= 1'b0;
			valid_s3   <= 1'b0;
			inflight_q <= '0;
		end else begin
			valid_s1 <= issue;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2 && last_s2;
			if (elem_done && !valid_s3) begin
				inflight_q <= inflight_q + CNT_W'(1);
			end else if (valid_s3 && !elem_done) begin
				inflight_q <= inflight_q - CNT_W'(1);
			end
		end
	end

	// Pipeline payload: tags, product and accumulator.
	always_ff @(posedge clk) begin
		if (issue) begin
			first_s1 <= (k_q == '0);
			last_s1  <= k_last;
			end_s1   <= run_done;
			row_s1   <= i_q;
			col_s1   <= j_q;
		end
		if (valid_s1) begin
			first_s2 <= first_s1;
			last_s2  <= last_s1;
			end_s2   <= end_s1;
			row_s2   <= row_s1;
			col_s2   <= col_s1;
			prod_s2  <= a_s1 * b_s1;
		end
		if (valid_s2) begin
			acc_q  <= acc_next;
			end_s3 <= end_s2;
			row_s3 <= row_s2;
			col_s3 <= col_s2;
		end
	end

	// Saturate the finished sum to the 32-bit result.
	assign acc_top  = acc_q[ACC_W-1:SUM_W-1];
	assign acc_fits = (&acc_top) || (~|acc_top);

	always_comb begin
		res_push      = valid_s3;
		res_data.row  = row_s3;
		res_data.col  = col_s3;
		res_data.last = end_s3;
		res_data.sat  = !acc_fits;
		if (acc_fits) begin
			res_data.sum = acc_q[SUM_W-1:0];
		end else if (acc_q[ACC_W-1]) begin
			res_data.sum = mmm_pkg::SUM_MIN;
		end else begin
			res_data.sum = mmm_pkg::SUM_MAX;
		end
	end

endmodule

### rtl/matrix_matrix_multiply_core.sv
// Top level of the matrix-matrix multiply core: front end, queues and back end.
//
// Usage: the input side is a queue. Present an item with push; it is taken at a
// rising edge where push is high and full is low. Opcode 0 loads one element of
// matrix A, opcode 1 one element of matrix B, both at row_index/col_index.
// Opcode 2 runs C = A * B with the current dimension registers and emits
// M*N results in row-major order; the final one carries last.
// The result side is also a queue: while empty is low the oldest result is on
// out_row, out_col, product_sum, saturated and last; pop takes it.
// Dimension registers are written through wr_en, wr_index and wr_data while
// the core is idle; a run captures them when it is accepted.
// A load is written to its element store as it leaves the command queue; a run
// leaves the queue, then issues its M*N*K multiply-accumulates to a single
// multiplier, each through the read, product and accumulator registers. A
// two-entry command queue lets the front end accept items during a run.
// Stalls: results wait in a four-entry queue; when it holds four (counting sums
// still in the pipeline) the sequencer pauses before the next result element.
// Reset clears the queues and the sequencer and sets all dimensions to 8; the
// element stores keep no reset value and must be loaded before use.
module matrix_matrix_multiply_core #(
	parameter int MAX_DIM    = mmm_pkg::MAX_DIM_DEF,
	parameter int ELEM_WIDTH = mmm_pkg::ELEM_WIDTH_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// Input channel.
	input  logic                                 push,
	output logic                                 full,
	input  logic [mmm_pkg::OPCODE_W-1:0]         opcode,
	input  logic [mmm_pkg::IDX_W-1:0]            row_index,
	input  logic [mmm_pkg::IDX_W-1:0]            col_index,
	input  logic signed [mmm_pkg::IN_ELEM_W-1:0] element_value,
	// Configuration port.
	input  logic                                 wr_en,
	input  logic [mmm_pkg::CFG_IDX_W-1:0]        wr_index,
	input  logic [mmm_pkg::DIM_W-1:0]            wr_data,
	// Result channel.
	output logic                                 empty,
	input  logic                                 pop,
	output logic [mmm_pkg::IDX_W-1:0]            out_row,
	output logic [mmm_pkg::IDX_W-1:0]            out_col,
	output logic signed [mmm_pkg::SUM_W-1:0]     product_sum,
	output logic                                 saturated,
	output logic                                 last
);

	logic                          cmd_full;
	logic                          cmd_push;
	logic                          cmd_empty;
	logic                          cmd_pop;
	mmm_pkg::cmd_t                 cmd_in;
	mmm_pkg::cmd_t                 cmd_head;
	logic                          res_push;
	logic [mmm_pkg::RES_CNT_W-1:0] res_count;
	mmm_pkg::result_t              res_in;
	mmm_pkg::result_t              res_head;

	// Decode and dimension registers.
	mmm_front #(
		.MAX_DIM (MAX_DIM)
	) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.push          (push),
		.full          (full),
		.opcode        (opcode),
		.row_index     (row_index),
		.col_index     (col_index),
		.element_value (element_value),
		.wr_en         (wr_en),
		.wr_index      (wr_index),
		.wr_data       (wr_data),
		.cmd_full      (cmd_full),
		.cmd_push      (cmd_push),
		.cmd_data      (cmd_in)
	);

	// Command queue between the front and back ends.
	mmm_fifo #(
		.T     (mmm_pkg::cmd_t),
		.DEPTH (mmm_pkg::CMD_DEPTH)
	) u_cmd_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (cmd_push),
		.wdata  (cmd_in),
		.full   (cmd_full),
		.pop    (cmd_pop),
		.rdata  (cmd_head),
		.empty  (cmd_empty),
		.count  ()
	);

	// Element stores and multiply-accumulate pipeline.
	mmm_back #(
		.MAX_DIM    (MAX_DIM),
		.ELEM_WIDTH (ELEM_WIDTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_empty (cmd_empty),
		.cmd_head  (cmd_head),
		.cmd_pop   (cmd_pop),
		.res_count (res_count),
		.res_push  (res_push),
		.res_data  (res_in)
	);

	// Result queue toward the receiver.
	mmm_fifo #(
		.T     (mmm_pkg::result_t),
		.DEPTH (mmm_pkg::RES_DEPTH)
	) u_res_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_push),
		.wdata  (res_in),
		.full   (),
		.pop    (pop),
		.rdata  (res_head),
		.empty  (empty),
		.count  (res_count)
	);

	assign out_row     = res_head.row;
	assign out_col     = res_head.col;
	assign product_sum = res_head.sum;
	assign saturated   = res_head.sat;
	assign last        = res_head.last;

endmodule

### rtl/mmm_checker.sv
// Port-level checks for the matrix-matrix multiply core, bound to its top level.
module mmm_checker (
	input logic                                 clk,
	input logic                                 arst_n,
	input logic                                 empty,
	input logic                                 pop,
	input logic [mmm_pkg::IDX_W-1:0]            out_row,
	input logic [mmm_pkg::IDX_W-1:0]            out_col,
	input logic signed [mmm_pkg::SUM_W-1:0]     product_sum,
	input logic                                 saturated,
	input logic                                 last
);

	logic run_start_q;

	// Tracks whether the next result opens a new run.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_start_q <= 1'b1;
		end else if (pop && !empty) begin
			run_start_q <= last;
		end
	end

	// A waiting result stays until it is taken.
	a_result_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> !empty)
		else $error("result withdrawn before it was taken");

	// A waiting result keeps its contents.
	a_result_stable: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> ($stable(product_sum) && $stable(out_row)
			&& $stable(out_col) && $stable(saturated) && $stable(last)))
		else $error("waiting result changed");

	// A clipped sum sits at one of the two limits.
	a_sat_value: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && saturated) |->
			(product_sum == mmm_pkg::SUM_MAX || product_sum == mmm_pkg::SUM_MIN))
		else $error("saturated result is not at a limit");

	// Each run starts at the top-left element.
	a_run_origin: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && run_start_q) |-> (out_row == '0 && out_col == '0))
		else $error("run did not start at row 0, column 0");

endmodule

bind matrix_matrix_multiply_core mmm_checker u_mmm_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.empty       (empty),
	.pop         (pop),
	.out_row     (out_row),
	.out_col     (out_col),
	.product_sum (product_sum),
	.saturated   (saturated),
	.last        (last)
);
